// ===== rtl/core/rgbct_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbct_pkg
// Shared widths, latencies and fixed-point constants of the color
// temperature and lux pipeline.
// ----------------------------------------------------------------------------
package rgbct_pkg;

  // Signed operand width of the divider, wide enough for X + Y + Z.
  localparam int DIV_W = 34;
  // Fraction bits added to the dividend (Q4.20 result).
  localparam int FRAC_W = 20;
  // Result width of the divider, saturated Q4.20.
  localparam int Q_W = 24;
  // Magnitude quotient bits below the saturation point.
  localparam int DIV_QBITS = Q_W - 1;
  // Divider pipeline registers: input register, one stage per quotient bit, output register.
  localparam int DIV_LAT = DIV_QBITS + 2;

  localparam logic signed [Q_W-1:0] Q20_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic signed [Q_W-1:0] Q20_MIN = {1'b1, {(Q_W-1){1'b0}}};

endpackage

// ===== rtl/core/rgb_to_color_temp_and_lux.sv =====
// ----------------------------------------------------------------------------
// rgb_to_color_temp_and_lux
// Correlated color temperature (McCamy) and illuminance from RGB counts.
// ----------------------------------------------------------------------------
// A word of red, green and blue counts is taken at each rising edge where
// start is high and busy is low. busy is low at all times outside reset, so
// one word may enter in every cycle and many words are in flight at once.
// Each word gives exactly one result: done is high for one cycle with
// color_temp_kelvin, illuminance and invalid. Results leave in order.
// The pipeline holds the two 25-stage divider steps in series
// (chromaticity x and y in parallel, then McCamy's n) plus nine stages of
// input, matrix, sum, subtract, polynomial and output work.
// Throughput is one word per cycle.
// invalid is set, with both results zero, when X+Y+Z or the denominator of
// n is zero. Otherwise both results saturate to 0..65535.
// Synchronous reset drops every word in flight; busy is high during reset.
// The receiver cannot stall: a result is gone after its cycle.
// ----------------------------------------------------------------------------
module rgb_to_color_temp_and_lux (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] red_count,
  input  logic [15:0] green_count,
  input  logic [15:0] blue_count,
  output logic        done,
  output logic [15:0] color_temp_kelvin,
  output logic [15:0] illuminance,
  output logic        invalid
);
  import rgbct_pkg::*;

  localparam int LAT = 2 * DIV_LAT + 9;
  localparam int ACC_W = 52;

  localparam logic signed [15:0] MX0 = -16'sd2340;
  localparam logic signed [15:0] MX1 = 16'sd25383;
  localparam logic signed [15:0] MX2 = -16'sd15670;
  localparam logic signed [15:0] MY0 = -16'sd5319;
  localparam logic signed [15:0] MY1 = 16'sd25860;
  localparam logic signed [15:0] MY2 = -16'sd11992;
  localparam logic signed [15:0] MZ0 = -16'sd11174;
  localparam logic signed [15:0] MZ1 = 16'sd12628;
  localparam logic signed [15:0] MZ2 = 16'sd9229;

  localparam logic signed [DIV_W-1:0] XC_REF = 34'sd348127;
  localparam logic signed [DIV_W-1:0] YC_REF = 34'sd194825;
  localparam logic signed [ACC_W-1:0] LIN_COEF = 52'sd111792947;
  localparam logic signed [ACC_W-1:0] C2_COEF = 52'sd3525;
  localparam logic signed [ACC_W-1:0] C3_COEF = 52'sd449;
  localparam logic signed [ACC_W-1:0] CONST_Q20 = 52'sd5788485550;

  typedef struct packed {
    logic        vld;
    logic        inv;
    logic [15:0] lux;
  } side_t;

  function automatic logic signed [DIV_W-1:0] mac3(
    input logic signed [15:0] k0,
    input logic signed [15:0] k1,
    input logic signed [15:0] k2,
    input logic [15:0] c0,
    input logic [15:0] c1,
    input logic [15:0] c2
  );
    logic signed [DIV_W-1:0] p0;
    logic signed [DIV_W-1:0] p1;
    logic signed [DIV_W-1:0] p2;
    p0 = DIV_W'(k0) * $signed({18'b0, c0});
    p1 = DIV_W'(k1) * $signed({18'b0, c1});
    p2 = DIV_W'(k2) * $signed({18'b0, c2});
    return p0 + p1 + p2;
  endfunction

  assign busy = rst;

  // Stage A: input word.
  logic        vld_a;
  logic [15:0] r_a, g_a, b_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
    end else begin
      vld_a <= start && !busy;
    end
    r_a <= red_count;
    g_a <= green_count;
    b_a <= blue_count;
  end

  // Stage B: tristimulus values at Q.14 scale.
  logic                    vld_b;
  logic signed [DIV_W-1:0] x_b, y_b, z_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_b <= 1'b0;
    end else begin
      vld_b <= vld_a;
    end
    x_b <= mac3(MX0, MX1, MX2, r_a, g_a, b_a);
    y_b <= mac3(MY0, MY1, MY2, r_a, g_a, b_a);
    z_b <= mac3(MZ0, MZ1, MZ2, r_a, g_a, b_a);
  end

  // Stage C: sum and lux.
  logic signed [DIV_W-1:0] x_c, y_c, s_c;
  logic signed [DIV_W-1:0] s_sum;
  logic [15:0]             lux_b;
  side_t                   side_c;

  assign s_sum = x_b + y_b + z_b;

  always_comb begin
    if (y_b[DIV_W-1]) begin
      lux_b = '0;
    end else if (y_b[DIV_W-2:30] != '0) begin
      lux_b = 16'hFFFF;
    end else begin
      lux_b = y_b[29:14];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_c.vld <= 1'b0;
    end else begin
      side_c.vld <= vld_b;
    end
    side_c.inv <= s_sum == '0;
    side_c.lux <= lux_b;
    x_c <= x_b;
    y_c <= y_b;
    s_c <= s_sum;
  end

  logic signed [Q_W-1:0] xc_q, yc_q;

  rgbct_div u_xdiv (.clk(clk), .a(x_c), .b(s_c), .q(xc_q));
  rgbct_div u_ydiv (.clk(clk), .a(y_c), .b(s_c), .q(yc_q));

  side_t sd1 [0:DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_LAT; k++) begin
        sd1[k].vld <= 1'b0;
      end
    end else begin
      sd1[0] <= side_c;
      for (int k = 1; k < DIV_LAT; k++) begin
        sd1[k] <= sd1[k-1];
      end
    end
  end

  // Stage D: numerator and denominator of n.
  logic signed [DIV_W-1:0] num_d, den_d, den_w;
  side_t                   side_d;

  assign den_w = YC_REF - DIV_W'(yc_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      side_d.vld <= 1'b0;
    end else begin
      side_d.vld <= sd1[DIV_LAT-1].vld;
    end
    side_d.inv <= sd1[DIV_LAT-1].inv || (den_w == '0);
    side_d.lux <= sd1[DIV_LAT-1].lux;
    num_d <= DIV_W'(xc_q) - XC_REF;
    den_d <= den_w;
  end

  logic signed [Q_W-1:0] n_q;

  rgbct_div u_ndiv (.clk(clk), .a(num_d), .b(den_d), .q(n_q));

  side_t sd2 [0:DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_LAT; k++) begin
        sd2[k].vld <= 1'b0;
      end
    end else begin
      sd2[0] <= side_d;
      for (int k = 1; k < DIV_LAT; k++) begin
        sd2[k] <= sd2[k-1];
      end
    end
  end

  // Polynomial stages. Arithmetic right shifts give floor division.
  logic signed [Q_W-1:0]   n_p1;
  logic signed [ACC_W-1:0] sq_p1, linp_p1;
  logic signed [ACC_W-1:0] n3p_p2, t2_p2, lin_p2;
  logic signed [ACC_W-1:0] t3_p3, sum_p3;
  logic signed [ACC_W-1:0] acc_p4;
  logic signed [ACC_W-1:0] n2_w, n3_w;
  logic [15:0]             cct_w;
  side_t                   sp [1:4];

  assign n2_w = sq_p1 >>> FRAC_W;
  assign n3_w = n3p_p2 >>> FRAC_W;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= 4; k++) begin
        sp[k].vld <= 1'b0;
      end
    end else begin
      sp[1] <= sd2[DIV_LAT-1];
      for (int k = 2; k <= 4; k++) begin
        sp[k] <= sp[k-1];
      end
    end
    n_p1    <= n_q;
    sq_p1   <= ACC_W'(n_q) * ACC_W'(n_q);
    linp_p1 <= ACC_W'(n_q) * LIN_COEF;
    n3p_p2  <= n2_w * ACC_W'(n_p1);
    t2_p2   <= n2_w * C2_COEF;
    lin_p2  <= linp_p1 >>> 14;
    t3_p3   <= n3_w * C3_COEF;
    sum_p3  <= t2_p2 + lin_p2 + CONST_Q20;
    acc_p4  <= t3_p3 + sum_p3;
  end

  always_comb begin
    if (acc_p4[ACC_W-1]) begin
      cct_w = '0;
    end else if (acc_p4[ACC_W-2:36] != '0) begin
      cct_w = 16'hFFFF;
    end else begin
      cct_w = acc_p4[35:20];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sp[4].vld;
    end
    invalid           <= sp[4].inv;
    color_temp_kelvin <= sp[4].inv ? 16'd0 : cct_w;
    illuminance       <= sp[4].inv ? 16'd0 : sp[4].lux;
  end

`ifndef SYNTH
  a_latency : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without a matching input word");

  a_no_loss : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT (done || rst))
    else $error("input word produced no result");

  a_invalid_zero : assert property (@(posedge clk) disable iff (rst)
    (done && invalid) |-> (color_temp_kelvin == 16'd0 && illuminance == 16'd0))
    else $error("invalid result carries nonzero values");
`endif

endmodule

// ===== rtl/core/rgbct_div.sv =====
// ----------------------------------------------------------------------------
// rgbct_div
// Pipelined signed restoring divider, one quotient bit per stage. Computes
// trunc(a * 2^20 / b) saturated to signed Q4.20. A zero divisor gives a
// saturated result that the caller discards.
// ----------------------------------------------------------------------------
module rgbct_div (
  input  logic                               clk,
  input  logic signed [rgbct_pkg::DIV_W-1:0] a,
  input  logic signed [rgbct_pkg::DIV_W-1:0] b,
  output logic signed [rgbct_pkg::Q_W-1:0]   q
);
  import rgbct_pkg::*;

  localparam int QB    = DIV_QBITS;
  localparam int REM_W = DIV_W + FRAC_W + 3;

  logic [DIV_W-1:0] a_mag;
  logic [DIV_W-1:0] b_mag;

  logic [REM_W-1:0] rem [0:QB-1];
  logic [DIV_W-1:0] dvs [0:QB-1];
  logic [QB-1:0]    quo [0:QB];
  logic             neg [0:QB];
  logic             ovf [0:QB];

  assign a_mag = a[DIV_W-1] ? DIV_W'(-a) : DIV_W'(a);
  assign b_mag = b[DIV_W-1] ? DIV_W'(-b) : DIV_W'(b);

  // The quotient magnitude reaches the saturation point exactly when |a| >= 8|b|.
  always_ff @(posedge clk) begin
    rem[0] <= REM_W'({a_mag, {FRAC_W{1'b0}}});
    dvs[0] <= b_mag;
    quo[0] <= '0;
    neg[0] <= a[DIV_W-1] ^ b[DIV_W-1];
    ovf[0] <= {3'b000, a_mag} >= {b_mag, 3'b000};
  end

  for (genvar k = 0; k < QB; k++) begin : g_stage
    localparam int SH = QB - 1 - k;
    logic [REM_W-1:0] trial;
    logic             ge;

    assign trial = REM_W'(dvs[k]) << SH;
    assign ge    = rem[k] >= trial;

    always_ff @(posedge clk) begin
      quo[k+1] <= {quo[k][QB-2:0], ge};
      neg[k+1] <= neg[k];
      ovf[k+1] <= ovf[k];
    end

    if (k < QB - 1) begin : g_rem
      always_ff @(posedge clk) begin
        rem[k+1] <= ge ? rem[k] - trial : rem[k];
        dvs[k+1] <= dvs[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ovf[QB]) begin
      q <= neg[QB] ? Q20_MIN : Q20_MAX;
    end else if (neg[QB]) begin
      q <= -$signed({1'b0, quo[QB]});
    end else begin
      q <= $signed({1'b0, quo[QB]});
    end
  end

endmodule
